// ===== rtl/led_driver_two_wire_frame_writer_macros.svh =====
// Assertion macros for the frame writer RTL.
// Depends on nothing; included by lddw_back, the module that carries checks.
`ifndef LED_DRIVER_TWO_WIRE_FRAME_WRITER_MACROS_SVH
`define LED_DRIVER_TWO_WIRE_FRAME_WRITER_MACROS_SVH
`ifndef SYNTHESIS
// Implication or plain property, checked on every rising edge out of reset.
`define LDDW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be seen on a rising edge out of reset.
`define LDDW_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define LDDW_ASSERT(lbl, clk, rst_n, prop, msg)
`define LDDW_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/lddw_pkg.sv =====
// Shared types and constants of the two-wire LED frame writer.
// Depends on nothing; imported by every module of the block.
package lddw_pkg;

  // Number of digits in one update, default for the top-level parameter
  localparam int DIGIT_COUNT_DEF = 4;
  // Segment bytes carried by one start word
  localparam int SEG_INPUTS = 4;
  // Depth of the queue between front and back
  localparam int Q_DEPTH = 2;

  // Fixed bytes of an update
  localparam logic [7:0] CMD_DATA   = 8'h40;
  localparam logic [7:0] CMD_ADDR   = 8'hC0;
  localparam logic [7:0] CTRL_RESET = 8'h8F;

  // Input word codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // One classified input word
  typedef struct packed {
    logic                             is_start;
    logic [SEG_INPUTS-1:0][7:0]       segs;
  } lddw_cmd_t;

endpackage

// ===== rtl/lddw_front.sv =====
// Front stage: accepts input words, classifies them and hands them to the queue.
// Depends on lddw_pkg.
module lddw_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_opcode,
  input  logic [7:0]          in_seg0,
  input  logic [7:0]          in_seg1,
  input  logic [7:0]          in_seg2,
  input  logic [7:0]          in_seg3,
  output logic                push,
  output lddw_pkg::lddw_cmd_t push_cmd,
  input  logic                q_ready
);
  import lddw_pkg::*;

  logic       fr_valid_r, fr_valid_nxt;
  lddw_cmd_t  fr_cmd_r;
  logic       in_take;

  // Stall only when a held word cannot move on
  assign in_stall = fr_valid_r && !q_ready;
  assign in_take  = in_valid && !in_stall;
  assign push     = fr_valid_r && q_ready;
  assign push_cmd = fr_cmd_r;

  // Advance or drop the held word
  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (in_take) begin
      fr_valid_nxt = 1'b1;
    end else if (push) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  // Classify and hold the payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      fr_cmd_r.is_start <= (in_opcode == OP_START);
      fr_cmd_r.segs     <= {in_seg3, in_seg2, in_seg1, in_seg0};
    end
  end

endmodule

// ===== rtl/lddw_queue.sv =====
// Short queue between the front stage and the pin sequencer.
// Depends on lddw_pkg.
module lddw_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lddw_pkg::lddw_cmd_t push_cmd,
  output logic                q_ready,
  input  logic                pop,
  output logic                q_valid,
  output lddw_pkg::lddw_cmd_t q_cmd
);
  import lddw_pkg::*;

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  lddw_cmd_t         entry_r [Q_DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;

  assign q_ready = (count_r != CW'(Q_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = entry_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/lddw_back.sv =====
// Back stage: runs the pin sequence of one update and registers the result word.
// Depends on lddw_pkg and the assertion macros header.
`include "led_driver_two_wire_frame_writer_macros.svh"
module lddw_back #(
  parameter int DIGIT_COUNT = lddw_pkg::DIGIT_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  lddw_pkg::lddw_cmd_t q_cmd,
  output logic                pop,
  input  logic [7:0]          ctrl_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_clk_level,
  output logic                out_dio_level,
  output logic                out_busy_res,
  output logic                out_last,
  output logic                out_rejected
);
  import lddw_pkg::*;

  localparam int KW = $clog2(DIGIT_COUNT + 1);

  // Sequencer states
  localparam logic [1:0] ST_START = 2'd0;
  localparam logic [1:0] ST_BYTE  = 2'd1;
  localparam logic [1:0] ST_STOP  = 2'd2;
  // Transactions of one update
  localparam logic [1:0] TR_DATA  = 2'd0;
  localparam logic [1:0] TR_ADDR  = 2'd1;
  localparam logic [1:0] TR_CTRL  = 2'd2;

  logic [1:0]      st_r, st_nxt;
  logic [1:0]      trans_r, trans_nxt;
  logic [1:0]      sub_r, sub_nxt;
  logic [3:0]      bitn_r, bitn_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic            running_r, running_nxt;
  logic            clock_pin_r, clock_pin_nxt;
  logic            data_pin_r, data_pin_nxt;
  logic [7:0]      seg_r [SEG_INPUTS];
  logic            seg_load;

  logic            out_valid_r, out_valid_nxt;
  logic            busy_r, last_r, rej_r;
  logic            busy_c, fin_c, rej_c;

  logic [2:0]      k_ext, seg_idx;
  logic [7:0]      cur_byte;
  logic            last_byte;

  // Take a queued word when the output register is free or being emptied
  assign pop = q_valid && (!out_valid_r || !out_stall);

  // Select the byte on the wire
  always_comb begin
    k_ext   = 3'(k_r);
    seg_idx = k_ext - 3'd1;
    case (trans_r)
      TR_DATA: cur_byte = CMD_DATA;
      TR_CTRL: cur_byte = ctrl_byte;
      default: begin
        if (k_r == '0) begin
          cur_byte = CMD_ADDR;
        end else if (seg_idx < 3'(SEG_INPUTS)) begin
          cur_byte = seg_r[seg_idx[1:0]];
        end else begin
          cur_byte = '0;
        end
      end
    endcase
    last_byte = (trans_r != TR_ADDR) || (k_r == KW'(DIGIT_COUNT));
  end

  // Step the pin sequence
  always_comb begin
    st_nxt        = st_r;
    trans_nxt     = trans_r;
    sub_nxt       = sub_r;
    bitn_nxt      = bitn_r;
    k_nxt         = k_r;
    running_nxt   = running_r;
    clock_pin_nxt = clock_pin_r;
    data_pin_nxt  = data_pin_r;
    seg_load      = 1'b0;
    busy_c        = 1'b0;
    fin_c         = 1'b0;
    rej_c         = 1'b0;
    if (pop) begin
      if (q_cmd.is_start) begin
        busy_c = 1'b1;
        if (running_r) begin
          rej_c = 1'b1;
        end else begin
          seg_load    = 1'b1;
          running_nxt = 1'b1;
          st_nxt      = ST_START;
          trans_nxt   = TR_DATA;
          sub_nxt     = '0;
          bitn_nxt    = '0;
          k_nxt       = '0;
        end
      end else if (running_r) begin
        busy_c = 1'b1;
        unique case (st_r)
          ST_START: begin
            if (sub_r == 2'd0) begin
              clock_pin_nxt = 1'b1;
              data_pin_nxt  = 1'b1;
              sub_nxt       = 2'd1;
            end else begin
              data_pin_nxt = 1'b0;
              st_nxt       = ST_BYTE;
              sub_nxt      = '0;
              bitn_nxt     = '0;
              k_nxt        = '0;
            end
          end
          ST_BYTE: begin
            if (!bitn_r[3]) begin
              // data bit: clock low, set data, clock high
              case (sub_r)
                2'd0:    clock_pin_nxt = 1'b0;
                2'd1:    data_pin_nxt  = cur_byte[bitn_r[2:0]];
                default: clock_pin_nxt = 1'b1;
              endcase
            end else begin
              // acknowledge clock with data released
              case (sub_r)
                2'd0: begin
                  clock_pin_nxt = 1'b0;
                  data_pin_nxt  = 1'b1;
                end
                2'd1:    clock_pin_nxt = 1'b1;
                default: clock_pin_nxt = 1'b0;
              endcase
            end
            if (sub_r == 2'd2) begin
              sub_nxt = '0;
              if (!bitn_r[3]) begin
                bitn_nxt = bitn_r + 4'd1;
              end else if (last_byte) begin
                st_nxt = ST_STOP;
              end else begin
                bitn_nxt = '0;
                k_nxt    = k_r + 1'b1;
              end
            end else begin
              sub_nxt = sub_r + 2'd1;
            end
          end
          ST_STOP: begin
            case (sub_r)
              2'd0:    clock_pin_nxt = 1'b0;
              2'd1:    data_pin_nxt  = 1'b0;
              2'd2:    clock_pin_nxt = 1'b1;
              default: data_pin_nxt  = 1'b1;
            endcase
            sub_nxt = sub_r + 2'd1;
            if (sub_r == 2'd3) begin
              st_nxt = ST_START;
              if (trans_r == TR_CTRL) begin
                fin_c       = 1'b1;
                running_nxt = 1'b0;
                trans_nxt   = TR_DATA;
              end else begin
                trans_nxt = trans_r + 2'd1;
              end
            end
          end
          default: begin
            st_nxt = ST_START;
          end
        endcase
      end
    end
  end

  // Hold the result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_START;
      trans_r     <= TR_DATA;
      sub_r       <= '0;
      bitn_r      <= '0;
      k_r         <= '0;
      running_r   <= 1'b0;
      clock_pin_r <= 1'b1;
      data_pin_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      trans_r     <= trans_nxt;
      sub_r       <= sub_nxt;
      bitn_r      <= bitn_nxt;
      k_r         <= k_nxt;
      running_r   <= running_nxt;
      clock_pin_r <= clock_pin_nxt;
      data_pin_r  <= data_pin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Latch segments and result flags
  always_ff @(posedge clk) begin
    if (seg_load) begin
      for (int i = 0; i < SEG_INPUTS; i++) begin
        seg_r[i] <= q_cmd.segs[i];
      end
    end
    if (pop) begin
      busy_r <= busy_c;
      last_r <= fin_c;
      rej_r  <= rej_c;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_clk_level = clock_pin_r;
  assign out_dio_level = data_pin_r;
  assign out_busy_res  = busy_r;
  assign out_last      = last_r;
  assign out_rejected  = rej_r;

  `LDDW_ASSERT(a_last_busy, clk, rst_n, out_valid_r && last_r |-> busy_r, "last word not busy")
  `LDDW_ASSERT_NEVER(a_last_rej, clk, rst_n, out_valid_r && last_r && rej_r, "last and rejected")
  `LDDW_ASSERT(a_rej_run, clk, rst_n, pop && q_cmd.is_start && running_r |=> rej_r && running_r, "busy start not rejected")
  `LDDW_ASSERT(a_fin_stop, clk, rst_n, pop && fin_c |=> !running_r && clock_pin_r && data_pin_r, "update end left pins low")
  `LDDW_ASSERT(a_idle_pins, clk, rst_n, pop && !q_cmd.is_start && !running_r |=> $stable(clock_pin_r) && $stable(data_pin_r), "idle tick moved pins")

endmodule

// ===== rtl/led_driver_two_wire_frame_writer.sv =====
// Two-wire LED driver frame writer: pin-level sequencer for one display update.
// Depends on lddw_pkg, lddw_front, lddw_queue and lddw_back.
//
// Input channel (in_valid / in_stall): one word per 10 us tick. A word with
// in_opcode 0 is a tick and advances the pin sequence by one step; a word with
// in_opcode 1 latches in_seg0..in_seg3 and starts an update, taking no tick.
// Result channel (out_valid / out_stall): exactly one word per input word, in
// order, giving the clock and data pin levels to hold for that tick, busy,
// the final-tick flag and the rejected flag for a start that came while busy.
// An update lasts 72 + 27 * (DIGIT_COUNT + 1) ticks, 207 at four digits.
// Configuration: cfg_we writes cfg_wdata as the display-control byte sent in
// the last transaction; write it only while the block is idle.
// Throughput is one word per cycle while out_stall is low; a word's result
// passes through the front register, the queue and the back output register.
// A stall on the result side fills the output register, then the two-entry
// queue and the front register, after which in_stall rises.
// Reset leaves both pins high, no update running and display control 0x8F.
module led_driver_two_wire_frame_writer #(
  parameter int DIGIT_COUNT = lddw_pkg::DIGIT_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_opcode,
  input  logic [7:0] in_seg0,
  input  logic [7:0] in_seg1,
  input  logic [7:0] in_seg2,
  input  logic [7:0] in_seg3,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_clk_level,
  output logic       out_dio_level,
  output logic       out_busy_res,
  output logic       out_last,
  output logic       out_rejected
);
  import lddw_pkg::*;

  logic [7:0] display_control_r;
  logic       push, pop, q_ready, q_valid;
  lddw_cmd_t  push_cmd, q_cmd;

  // Hold the display-control byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_control_r <= CTRL_RESET;
    end else if (cfg_we) begin
      display_control_r <= cfg_wdata;
    end
  end

  lddw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_opcode(in_opcode),
    .in_seg0  (in_seg0),
    .in_seg1  (in_seg1),
    .in_seg2  (in_seg2),
    .in_seg3  (in_seg3),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready)
  );

  lddw_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .q_ready (q_ready),
    .pop     (pop),
    .q_valid (q_valid),
    .q_cmd   (q_cmd)
  );

  lddw_back #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .pop          (pop),
    .ctrl_byte    (display_control_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_clk_level(out_clk_level),
    .out_dio_level(out_dio_level),
    .out_busy_res (out_busy_res),
    .out_last     (out_last),
    .out_rejected (out_rejected)
  );

endmodule
